// File: design/iucm_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the interval union coverage map.
package iucm_pkg;

    localparam int FIELD_BITS = 16;
    localparam int COUNT_BITS = 16;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_NEXT  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic RUN_FOUND = 1'b0;
    localparam logic RUN_NONE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_LO,
        ST_ADD_HI,
        ST_SKIP,
        ST_RUN,
        ST_EMIT
    } t_state;

endpackage

// File: design/iucm_map_ram.sv
`timescale 1ns / 1ps
// Difference map storage: one write port, one read port, registered read data.
module iucm_map_ram #(
    parameter int ADDR_BITS = 16,
    parameter int DATA_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/interval_union_coverage_map_unit.sv
`timescale 1ns / 1ps
// Interval union coverage map: difference map over a signed domain, reported as covered runs.
//
// The map holds 2**VALUE_BITS counters in one synchronous RAM. After reset and after a
// clear request the block sweeps the RAM to zero, one entry per cycle, and takes no
// request meanwhile. An add request makes two read-modify-write updates on the single
// write port, one when its high bound is the top of the domain, none when it is dropped.
// A next-run request walks the map one entry per cycle from the scan cursor over the gap
// and the run, then hands the result to the output register once that register is free.
// A request on an exhausted scan answers without walking the map. The output
// register lets add and clear requests proceed while a result waits to be taken.
module interval_union_coverage_map_unit
    import iucm_pkg::*;
#(
    parameter int VALUE_BITS    = 16,
    parameter int MAX_INTERVALS = 65535
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic signed [FIELD_BITS-1:0] i_range_low,
    input  logic signed [FIELD_BITS-1:0] i_range_high,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [FIELD_BITS-1:0] o_run_low,
    output logic signed [FIELD_BITS-1:0] o_run_high,
    output logic                         o_run_status
);

    localparam int VB = VALUE_BITS;
    localparam int WB = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int SW = WB + 1;
    localparam logic signed [SW-1:0] DOM_MAX =
        SW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] DOM_MIN  = ~DOM_MAX;
    localparam logic [VB:0]          DOM_SIZE = {1'b1, {VB{1'b0}}};
    localparam logic [VB-1:0]        LAST_IDX = {VB{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_MAX = COUNT_BITS'(MAX_INTERVALS);

    t_state r_state, n_state;
    logic [VB:0]            r_cursor, n_cursor;
    logic [FIELD_BITS-1:0]  r_cover, n_cover;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [VB-1:0]          r_start, n_start;
    logic [VB-1:0]          r_lo_idx, n_lo_idx;
    logic [VB-1:0]          r_hi_idx, n_hi_idx;
    logic                   r_hi_top, n_hi_top;
    logic [VB-1:0]          r_clr_idx, n_clr_idx;
    logic [FIELD_BITS-1:0]  r_res_low, n_res_low;
    logic [FIELD_BITS-1:0]  r_res_high, n_res_high;
    logic                   r_res_status, n_res_status;
    logic                   r_out_valid, n_out_valid;
    logic [FIELD_BITS-1:0]  r_out_low, n_out_low;
    logic [FIELD_BITS-1:0]  r_out_high, n_out_high;
    logic                   r_out_status, n_out_status;

    logic                   in_fire;
    logic                   slot_free;
    logic signed [SW-1:0]   lo_ext, hi_ext, lo_c, hi_c;
    logic                   add_ok;
    logic [VB-1:0]          lo_idx_c, hi_idx_c;
    logic                   hi_top_c;
    logic [FIELD_BITS-1:0]  mem_q, cover_sum;
    logic                   cur_last;
    logic                   mem_we;
    logic [VB-1:0]          mem_waddr, mem_raddr;
    logic [FIELD_BITS-1:0]  mem_wdata;

    function automatic logic [FIELD_BITS-1:0] idx_to_val(input logic [VB-1:0] idx);
        logic signed [VB-1:0] v;
        logic signed [WB-1:0] w;
        v = signed'({~idx[VB-1], idx[VB-2:0]});
        w = WB'(v);
        return w[FIELD_BITS-1:0];
    endfunction

    iucm_map_ram #(
        .ADDR_BITS(VB),
        .DATA_BITS(FIELD_BITS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_q)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    // clip interval to the domain
    assign lo_ext   = SW'(i_range_low);
    assign hi_ext   = SW'(i_range_high);
    assign lo_c     = (lo_ext < DOM_MIN) ? DOM_MIN : lo_ext;
    assign hi_c     = (hi_ext > DOM_MAX) ? DOM_MAX : hi_ext;
    assign add_ok   = (lo_c <= hi_c) && (r_count < CNT_MAX);
    assign lo_idx_c = {~lo_c[VB-1], lo_c[VB-2:0]};
    assign hi_idx_c = {~hi_c[VB-1], hi_c[VB-2:0]} + VB'(1);
    assign hi_top_c = (hi_c == DOM_MAX);

    assign cover_sum = r_cover + mem_q;
    assign cur_last  = (r_cursor[VB-1:0] == LAST_IDX);

    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_cover      = r_cover;
        n_count      = r_count;
        n_start      = r_start;
        n_lo_idx     = r_lo_idx;
        n_hi_idx     = r_hi_idx;
        n_hi_top     = r_hi_top;
        n_clr_idx    = r_clr_idx;
        n_res_low    = r_res_low;
        n_res_high   = r_res_high;
        n_res_status = r_res_status;
        case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + VB'(1);
                if (r_clr_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_opcode)
                        OP_ADD: begin
                            n_cursor = '0;
                            n_cover  = '0;
                            if (add_ok) begin
                                n_lo_idx = lo_idx_c;
                                n_hi_idx = hi_idx_c;
                                n_hi_top = hi_top_c;
                                n_count  = r_count + COUNT_BITS'(1);
                                n_state  = ST_ADD_LO;
                            end
                        end
                        OP_NEXT: begin
                            if (r_cursor == DOM_SIZE) begin
                                n_res_low    = '0;
                                n_res_high   = '0;
                                n_res_status = RUN_NONE;
                                n_state      = ST_EMIT;
                            end else begin
                                n_state = ST_SKIP;
                            end
                        end
                        OP_CLEAR: begin
                            n_cursor  = '0;
                            n_cover   = '0;
                            n_count   = '0;
                            n_clr_idx = '0;
                            n_state   = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD_LO: begin
                n_state = r_hi_top ? ST_IDLE : ST_ADD_HI;
            end
            ST_ADD_HI: begin
                n_state = ST_IDLE;
            end
            ST_SKIP: begin
                n_cursor = r_cursor + (VB+1)'(1);
                if (cover_sum == '0) begin
                    n_cover = '0;
                    if (cur_last) begin
                        n_res_low    = '0;
                        n_res_high   = '0;
                        n_res_status = RUN_NONE;
                        n_state      = ST_EMIT;
                    end
                end else begin
                    n_cover = cover_sum;
                    n_start = r_cursor[VB-1:0];
                    if (cur_last) begin
                        n_res_low    = idx_to_val(r_cursor[VB-1:0]);
                        n_res_high   = idx_to_val(LAST_IDX);
                        n_res_status = RUN_FOUND;
                        n_state      = ST_EMIT;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (cover_sum == '0) begin
                    // leave the cursor on the uncovered entry
                    n_res_low    = idx_to_val(r_start);
                    n_res_high   = idx_to_val(r_cursor[VB-1:0] - VB'(1));
                    n_res_status = RUN_FOUND;
                    n_state      = ST_EMIT;
                end else begin
                    n_cover  = cover_sum;
                    n_cursor = r_cursor + (VB+1)'(1);
                    if (cur_last) begin
                        n_res_low    = idx_to_val(r_start);
                        n_res_high   = idx_to_val(LAST_IDX);
                        n_res_status = RUN_FOUND;
                        n_state      = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_idx;
        mem_wdata = '0;
        mem_raddr = r_cursor[VB-1:0] + VB'(1);
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                if (in_fire && i_opcode == OP_ADD) begin
                    mem_raddr = lo_idx_c;
                end else begin
                    mem_raddr = r_cursor[VB-1:0];
                end
            end
            ST_ADD_LO: begin
                mem_we    = 1'b1;
                mem_waddr = r_lo_idx;
                mem_wdata = mem_q + FIELD_BITS'(1);
                mem_raddr = r_hi_idx;
            end
            ST_ADD_HI: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi_idx;
                mem_wdata = mem_q - FIELD_BITS'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_low    = r_out_low;
        n_out_high   = r_out_high;
        n_out_status = r_out_status;
        if (r_state == ST_EMIT && slot_free) begin
            n_out_valid  = 1'b1;
            n_out_low    = r_res_low;
            n_out_high   = r_res_high;
            n_out_status = r_res_status;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cursor    <= '0;
            r_cover     <= '0;
            r_count     <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_cover     <= n_cover;
            r_count     <= n_count;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start      <= n_start;
        r_lo_idx     <= n_lo_idx;
        r_hi_idx     <= n_hi_idx;
        r_hi_top     <= n_hi_top;
        r_res_low    <= n_res_low;
        r_res_high   <= n_res_high;
        r_res_status <= n_res_status;
        r_out_low    <= n_out_low;
        r_out_high   <= n_out_high;
        r_out_status <= n_out_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_run_low    = signed'(r_out_low);
    assign o_run_high   = signed'(r_out_high);
    assign o_run_status = r_out_status;

`ifndef ASSERT_OFF
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= DOM_SIZE)
        else $error("scan cursor past end of domain");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("interval count past limit");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_run_status == RUN_NONE |-> o_run_low == '0 && o_run_high == '0)
        else $error("no-run result carries nonzero bounds");

    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_opcode == OP_CLEAR |=> r_state == ST_CLEAR && r_count == '0
            && r_clr_idx == '0)
        else $error("clear request did not start sweep");

    a_add_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADD_LO && !r_hi_top |=> r_state == ST_ADD_HI && $past(mem_we))
        else $error("add update sequence broken");
`endif

endmodule

// File: tb/iucm_checker.sv
`timescale 1ns / 1ps
// Checker for the interval union coverage map unit: predicts each covered run or end-of-scan answer and compares.
module iucm_checker
    import iucm_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic signed [FIELD_BITS-1:0] i_range_low,
    input  logic signed [FIELD_BITS-1:0] i_range_high,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic signed [FIELD_BITS-1:0] i_run_low,
    input  logic signed [FIELD_BITS-1:0] i_run_high,
    input  logic                         i_run_status,
    output int                           o_fail_count,
    output int                           o_pending_count,
    output int                           o_found_count,
    output int                           o_none_count
);

    localparam int DOMAIN_SIZE  = 1 << FIELD_BITS;
    localparam int DOMAIN_BASE  = -(1 << (FIELD_BITS - 1));
    localparam int TOP_VALUE    = (1 << (FIELD_BITS - 1)) - 1;
    localparam int MAP_CAPACITY = 65535;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] low;
        logic signed [FIELD_BITS-1:0] high;
        logic                         status;
    } t_run;

    logic [16:0]           diff_map [DOMAIN_SIZE];
    int                    scan_pos;
    logic [COUNT_BITS-1:0] prefix_cover;
    int                    live_intervals;
    t_run                  run_q[$];
    int                    fails = 0;
    int                    found = 0;
    int                    nones = 0;

    function automatic logic [COUNT_BITS-1:0] cover_at(int idx);
        return prefix_cover + diff_map[idx][COUNT_BITS-1:0];
    endfunction

    task automatic clear_map();
        foreach (diff_map[k]) diff_map[k] = '0;
        scan_pos       = 0;
        prefix_cover   = '0;
        live_intervals = 0;
    endtask

    // every add restarts the scan, even when it is dropped
    task automatic add_interval(int lo, int hi);
        scan_pos     = 0;
        prefix_cover = '0;
        if (lo <= hi && live_intervals < MAP_CAPACITY) begin
            diff_map[lo - DOMAIN_BASE] += 17'd1;
            if (hi != TOP_VALUE) begin
                diff_map[hi - DOMAIN_BASE + 1] -= 17'd1;
            end
            live_intervals++;
        end
    endtask

    task automatic next_run();
        int   first;
        t_run r;
        while (scan_pos < DOMAIN_SIZE && cover_at(scan_pos) == '0) begin
            prefix_cover = '0;
            scan_pos++;
        end
        if (scan_pos >= DOMAIN_SIZE) begin
            r.low    = '0;
            r.high   = '0;
            r.status = RUN_NONE;
        end else begin
            first        = scan_pos;
            prefix_cover = cover_at(scan_pos);
            scan_pos++;
            while (scan_pos < DOMAIN_SIZE && cover_at(scan_pos) != '0) begin
                prefix_cover = cover_at(scan_pos);
                scan_pos++;
            end
            r.low    = FIELD_BITS'(first + DOMAIN_BASE);
            r.high   = FIELD_BITS'(scan_pos - 1 + DOMAIN_BASE);
            r.status = RUN_FOUND;
        end
        run_q.insert(run_q.size(), r);
    endtask

    always @(posedge i_clk) begin
        t_run want;
        if (!i_rst_n) begin
            clear_map();
            run_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (run_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: result with no request pending: %0d %0d %0b",
                                 $time, i_run_low, i_run_high, i_run_status);
                    end
                end else begin
                    want = run_q.pop_front();
                    if (want.status == RUN_NONE) nones++;
                    else found++;
                    if (i_run_low !== want.low || i_run_high !== want.high
                        || i_run_status !== want.status) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display(
                                "%0t: mismatch: want %0d..%0d st %0b, got %0d..%0d st %0b",
                                $time, want.low, want.high, want.status,
                                i_run_low, i_run_high, i_run_status);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_opcode)
                    OP_ADD:   add_interval(i_range_low, i_range_high);
                    OP_NEXT:  next_run();
                    OP_CLEAR: clear_map();
                    default:  ;
                endcase
            end
        end
        o_fail_count    <= fails;
        o_pending_count <= run_q.size();
        o_found_count   <= found;
        o_none_count    <= nones;
    end

endmodule

// File: tb/tb_interval_union_coverage_map_unit.sv
`timescale 1ns / 1ps
// Testbench top for the interval union coverage map unit: request stimulus and verdict.
module tb_interval_union_coverage_map_unit;
    import iucm_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int DOMAIN_BASE  = -32768;
    localparam int TOP_VALUE    = 32767;
    localparam int WIN_SPAN     = 512;
    localparam int PHASE_ITEMS  = 210;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_in_valid   = 1'b0;
    logic                         o_in_ready;
    logic [1:0]                   i_opcode     = OP_NOP;
    logic signed [FIELD_BITS-1:0] i_range_low  = '0;
    logic signed [FIELD_BITS-1:0] i_range_high = '0;
    logic                         o_out_valid;
    logic                         i_out_ready  = 1'b0;
    logic signed [FIELD_BITS-1:0] o_run_low;
    logic signed [FIELD_BITS-1:0] o_run_high;
    logic                         o_run_status;

    int fail_total;
    int pending_total;
    int found_total;
    int none_total;

    int tx_idle_pct = 9;
    int rx_idle_pct = 80;
    int n_items     = 0;
    int n_adds      = 0;
    int n_nexts     = 0;
    int n_clears    = 0;
    int n_other     = 0;

    // shadow of coverage in the low window, used to bound the number of run requests
    bit [WIN_SPAN-1:0] window_cov = '0;

    interval_union_coverage_map_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_run_low    (o_run_low),
        .o_run_high   (o_run_high),
        .o_run_status (o_run_status)
    );

    iucm_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_range_low     (i_range_low),
        .i_range_high    (i_range_high),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_run_low       (o_run_low),
        .i_run_high      (o_run_high),
        .i_run_status    (o_run_status),
        .o_fail_count    (fail_total),
        .o_pending_count (pending_total),
        .o_found_count   (found_total),
        .o_none_count    (none_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic int rand_value();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int window_runs();
        int runs;
        runs = 0;
        for (int k = 0; k < WIN_SPAN; k++) begin
            if (window_cov[k] && (k == 0 || !window_cov[k-1])) runs++;
        end
        return runs;
    endfunction

    task automatic send_request(input logic [1:0] op, input int lo, input int hi);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_range_low  <= FIELD_BITS'(lo);
        i_range_high <= FIELD_BITS'(hi);
        do @(posedge i_clk); while (!o_in_ready);
        case (op)
            OP_ADD: begin
                n_adds++;
                if (lo <= hi) begin
                    n_items++;
                end
            end
            OP_NEXT: begin
                n_items++;
                n_nexts++;
            end
            OP_CLEAR: begin
                n_items++;
                n_clears++;
            end
            default: n_other++;
        endcase
    endtask

    task automatic send_next();
        send_request(OP_NEXT, rand_value(), rand_value());
    endtask

    task automatic add_window(int lo_off, int hi_off);
        send_request(OP_ADD, DOMAIN_BASE + lo_off, DOMAIN_BASE + hi_off);
        for (int k = lo_off; k <= hi_off; k++) window_cov[k] = 1'b1;
    endtask

    // empty adds with full-range bounds, or unused opcodes
    task automatic send_noise();
        int a;
        int b;
        if ($urandom_range(1) == 1) begin
            send_request(OP_NOP, rand_value(), rand_value());
        end else begin
            do begin
                a = rand_value();
                b = rand_value();
            end while (a == b);
            if (a > b) send_request(OP_ADD, a, b);
            else send_request(OP_ADD, b, a);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_total != 0);
    endtask

    task automatic add_random_window();
        int lo_off;
        int hi_off;
        lo_off = $urandom_range(WIN_SPAN - 1);
        if ($urandom_range(7) == 0) hi_off = lo_off + int'($urandom_range(40));
        else hi_off = lo_off + int'($urandom_range(3));
        if (hi_off > WIN_SPAN - 1) hi_off = WIN_SPAN - 1;
        add_window(lo_off, hi_off);
    endtask

    // adds in the low window, then no more run requests than runs present there
    task automatic window_sequence();
        int n_req;
        repeat ($urandom_range(1, 4)) begin
            add_random_window();
            if ($urandom_range(9) == 0) send_noise();
        end
        n_req = $urandom_range(1, window_runs());
        repeat (n_req) begin
            send_next();
            if ($urandom_range(11) == 0) send_noise();
        end
        if ($urandom_range(7) == 0) drain_results();
    endtask

    // window adds and far intervals anywhere in the domain, then a scan run past its end
    task automatic sweep_sequence();
        int n_far;
        int a;
        int b;
        int t;
        repeat ($urandom_range(1, 3)) add_random_window();
        n_far = $urandom_range(2, 4);
        repeat (n_far) begin
            a = rand_value();
            case ($urandom_range(2))
                0: begin
                    b = a + int'($urandom_range(20));
                    if (b > TOP_VALUE) b = TOP_VALUE;
                end
                1: b = TOP_VALUE;
                default: begin
                    b = rand_value();
                    if (a > b) begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
            endcase
            send_request(OP_ADD, a, b);
        end
        repeat (window_runs() + n_far + 2) send_next();
    endtask

    initial begin
        #(80_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int phase_start;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty map, bounds at both ends, empty intervals, exhausted scan, restart
        send_next();
        send_next();
        send_request(OP_ADD, DOMAIN_BASE, DOMAIN_BASE);
        send_request(OP_ADD, -32766, -32760);
        send_request(OP_ADD, -32761, -32750);
        send_request(OP_ADD, 5, 3);
        send_request(OP_ADD, 32760, TOP_VALUE);
        send_request(OP_ADD, TOP_VALUE, TOP_VALUE);
        send_request(OP_ADD, -1, 0);
        send_request(OP_ADD, TOP_VALUE, DOMAIN_BASE);
        send_next();
        send_request(OP_NOP, -1, -1);
        send_next();
        send_next();
        send_next();
        send_next();
        send_next();
        send_request(OP_ADD, -32767, -32767);
        send_next();
        drain_results();
        send_next();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 80;
                end
                1: begin
                    tx_idle_pct = 80;
                    rx_idle_pct = 9;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            send_request(OP_CLEAR, rand_value(), rand_value());
            window_cov  = '0;
            phase_start = n_items;
            while (n_items - phase_start < PHASE_ITEMS) window_sequence();
            sweep_sequence();
        end

        // repeated adds stack counts on the same entries
        repeat (3) send_request(OP_ADD, DOMAIN_BASE + 100, DOMAIN_BASE + 103);
        repeat (window_runs() + 6) send_next();
        send_request(OP_CLEAR, rand_value(), rand_value());
        window_cov = '0;
        send_next();
        add_window(10, 20);
        send_next();

        drain_results();
        repeat (64) @(posedge i_clk);

        $display("Sent %0d adds, %0d run requests, %0d clears, %0d unused opcodes.",
                 n_adds, n_nexts, n_clears, n_other);
        $display("Compared %0d covered runs and %0d end-of-scan answers.",
                 found_total, none_total);
        if (fail_total == 0 && pending_total == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
design/iucm_pkg.sv
design/iucm_map_ram.sv
design/interval_union_coverage_map_unit.sv
tb/iucm_checker.sv
tb/tb_interval_union_coverage_map_unit.sv
